@@ sv/bsp_pkg.sv @@
`default_nettype none

package bsp_pkg;

  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  // Quotient width of the divider chain; also its number of cells.
  localparam int DIV_W             = 33;
  // Width of the rotator's x, y and z values (Q28).
  localparam int ZW                = 32;
  // Width of the product angle * fraction and of its range reduction.
  localparam int TW                = 34;

  localparam logic signed [TW-1:0] Q28_ONE   = 34'sd268435456;
  localparam logic signed [TW-1:0] Q28_PI    = 34'sd843314857;
  localparam logic signed [TW-1:0] Q28_HPI   = 34'sd421657428;
  localparam logic signed [TW-1:0] Q28_TWOPI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] Q28_KINV  = 32'sd163008219;

  // ceil(2^26 / 6); exact floor division by six for values below 2^25.
  localparam logic [23:0] RECIP6 = 24'd11184811;

  typedef struct packed {
    logic        x_neg;
    logic        ser;
    logic        lat_neg;
    logic        ax_neg;
    logic [15:0] mag;
    logic [12:0] slat;
    logic [17:0] sax;
  } axis_side_t;

  typedef struct packed {
    logic [15:0]      len;
    axis_side_t [1:0] ax;
  } side_t;

  typedef struct packed {
    logic signed [ZW-1:0] x;
    logic signed [ZW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [15:0]      rem;
  } dlane_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/bent_segment_point_unit.sv @@
`default_nettype none

// Point on a segment of constant curvature bent about two axes. One beat is
// taken in every clock cycle (busy stays low) and its result appears on the
// out_ ports, marked by out_valid for one cycle, after passing through the
// six-stage series and angle-reduction front end, the row of N rotation
// cells (CORDIC_STAGES, at most 24), the numerator and rounding registers,
// the row of 33 divider cells, one quotient bit each, and the output register.
// Results must be taken when shown.
// small_angle_limit may only be written while no beat is in flight.
module bent_segment_point_unit import bsp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_bend_x,
  input  logic signed [15:0] in_bend_y,
  input  logic [15:0]        in_fraction,
  input  logic [15:0]        in_seg_length,
  output logic               out_valid,
  output logic signed [16:0] out_pos_x,
  output logic signed [17:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int NCS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int CW  = DIV_W + 2;

  logic [7:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 8'd1;
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  logic signed [15:0] bend [2];
  assign bend[0] = in_bend_x;
  assign bend[1] = in_bend_y;

  logic       cv    [NCS+1];
  rot_t [1:0] crot  [NCS+1];
  side_t      cside [NCS+1];

  bsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_bend  (bend),
    .in_frac  (in_fraction),
    .in_len   (in_seg_length),
    .in_lim   (lim_r),
    .out_vld  (cv[0]),
    .out_rot  (crot[0]),
    .out_side (cside[0])
  );

  for (genvar i = 0; i < NCS; i++) begin : g_rot
    bsp_cordic_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (cv[i]),
      .in_rot   (crot[i]),
      .in_side  (cside[i]),
      .out_vld  (cv[i+1]),
      .out_rot  (crot[i+1]),
      .out_side (cside[i+1])
    );
  end

  // Numerators l * (1 - cos) and l * sin, both Q28.
  logic                 m1_vld_r;
  logic signed [50:0]   nlat1_r [2];
  logic signed [49:0]   nax1_r  [2];
  side_t                side_m1_r;
  logic signed [50:0]   nlat_nxt [2];
  logic signed [49:0]   nax_nxt  [2];
  logic signed [TW-1:0] cosv [2];
  logic signed [TW-1:0] diff [2];
  logic signed [16:0]   len_s;

  always_comb begin
    len_s = $signed({1'b0, cside[NCS].len});
    for (int k = 0; k < 2; k++) begin
      cosv[k]     = crot[NCS][k].flip ? -TW'(crot[NCS][k].x) : TW'(crot[NCS][k].x);
      diff[k]     = Q28_ONE - cosv[k];
      nlat_nxt[k] = len_s * diff[k];
      nax_nxt[k]  = len_s * crot[NCS][k].y;
    end
  end

  // Rounding to nearest adds half the divisor; the divisor |a| * 2^15 then
  // drops its power of two against the dividend.
  logic               m2_vld_r;
  dlane_t [3:0]       lane_m2_r;
  side_t              side_m2_r;
  dlane_t [3:0]       lane_nxt;
  side_t              side_m2_nxt;
  logic [50:0]        ulat [2];
  logic [49:0]        uax  [2];
  logic [50:0]        blat [2];
  logic [49:0]        bax  [2];

  always_comb begin
    side_m2_nxt = side_m1_r;
    for (int k = 0; k < 2; k++) begin
      ulat[k] = nlat1_r[k][50] ? 51'(-nlat1_r[k]) : nlat1_r[k];
      uax[k]  = nax1_r[k][49] ? 50'(-nax1_r[k]) : nax1_r[k];
      blat[k] = ulat[k] + {21'd0, side_m1_r.ax[k].mag, 14'd0};
      bax[k]  = uax[k] + {20'd0, side_m1_r.ax[k].mag, 14'd0};
      lane_nxt[2*k].num   = blat[k][DIV_W+14:15];
      lane_nxt[2*k].rem   = '0;
      lane_nxt[2*k+1].num = bax[k][DIV_W+14:15];
      lane_nxt[2*k+1].rem = '0;
      side_m2_nxt.ax[k].lat_neg = nlat1_r[k][50] ^ side_m1_r.ax[k].x_neg;
      side_m2_nxt.ax[k].ax_neg  = nax1_r[k][49] ^ side_m1_r.ax[k].x_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= cv[NCS];
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    nlat1_r   <= nlat_nxt;
    nax1_r    <= nax_nxt;
    side_m1_r <= cside[NCS];
    lane_m2_r <= lane_nxt;
    side_m2_r <= side_m2_nxt;
  end

  logic         dv    [DIV_W+1];
  dlane_t [3:0] dlane [DIV_W+1];
  side_t        dside [DIV_W+1];

  assign dv[0]    = m2_vld_r;
  assign dlane[0] = lane_m2_r;
  assign dside[0] = side_m2_r;

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    bsp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv[i]),
      .in_lane  (dlane[i]),
      .in_side  (dside[i]),
      .out_vld  (dv[i+1]),
      .out_lane (dlane[i+1]),
      .out_side (dside[i+1])
    );
  end

  function automatic logic signed [16:0] sat17(input logic signed [CW:0] v);
    logic signed [16:0] r;
    if (v > 36'sd65535) begin
      r = 17'sd65535;
    end else if (v < -36'sd65535) begin
      r = -17'sd65535;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [CW:0] v);
    logic signed [17:0] r;
    if (v > 36'sd131070) begin
      r = 18'sd131070;
    end else if (v < -36'sd131070) begin
      r = -18'sd131070;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  logic               out_valid_r;
  logic signed [16:0] pos_x_r, pos_z_r;
  logic signed [17:0] pos_y_r;
  logic signed [CW-1:0] latv [2];
  logic signed [CW-1:0] axv  [2];
  logic signed [CW-1:0] qlat [2];
  logic signed [CW-1:0] qax  [2];
  logic signed [CW-1:0] slat [2];
  logic signed [CW:0]   sum_y;
  logic signed [CW:0]   neg_x, neg_z;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      qlat[k] = $signed({2'b00, dlane[DIV_W][2*k].num});
      qax[k]  = $signed({2'b00, dlane[DIV_W][2*k+1].num});
      slat[k] = $signed({22'd0, dside[DIV_W].ax[k].slat});
      if (dside[DIV_W].ax[k].ser) begin
        latv[k] = dside[DIV_W].ax[k].x_neg ? -slat[k] : slat[k];
        axv[k]  = $signed({17'd0, dside[DIV_W].ax[k].sax});
      end else begin
        latv[k] = dside[DIV_W].ax[k].lat_neg ? -qlat[k] : qlat[k];
        axv[k]  = dside[DIV_W].ax[k].ax_neg ? -qax[k] : qax[k];
      end
    end
    neg_x = -(CW+1)'(latv[0]);
    neg_z = -(CW+1)'(latv[1]);
    sum_y = (CW+1)'(axv[0]) + (CW+1)'(axv[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= sat17(neg_x);
    pos_y_r <= sat18(sum_y);
    pos_z_r <= sat17(neg_z);
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_pos_z = pos_z_r;

`ifndef ASSERT_OFF
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(m2_vld_r, DIV_W + 1))
    else $error("result beat without a matching divider entry");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_x <= 17'sd65535 && out_pos_x >= -17'sd65535 &&
                   out_pos_z <= 17'sd65535 && out_pos_z >= -17'sd65535))
    else $error("lateral coordinate outside its range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_y <= 18'sd131070 && out_pos_y >= -18'sd131070))
    else $error("axial coordinate outside its range");
`endif

endmodule

`default_nettype wire

@@ sv/bsp_front.sv @@
`default_nettype none

module bsp_front import bsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_bend [2],
  input  logic [15:0]        in_frac,
  input  logic [15:0]        in_len,
  input  logic [7:0]         in_lim,
  output logic               out_vld,
  output rot_t [1:0]         out_rot,
  output side_t              out_side
);

  logic [15:0] mag [2];
  logic        ser [2];
  logic [16:0] neg17 [2];

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [TW-1:0] th1_r [2];
  logic signed [TW-1:0] th2_r [2];
  logic [31:0]          lf1_r, lf2_r, lf3_r, lf4_r;
  logic [31:0]          ff1_r;
  logic [23:0]          fm1_r [2];
  logic [15:0]          msq1_r [2];
  logic [55:0]          latp2_r [2];
  logic [47:0]          q2_r [2];
  logic [22:0]          qp3_r [2];
  logic [20:0]          term4_r [2];
  logic [62:0]          axp5_r [2];
  side_t                side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  rot_t [1:0]           rot3_r, rot4_r, rot5_r, rot6_r;

  logic signed [TW-1:0] th2_nxt [2];
  rot_t [1:0]           rot3_nxt;
  side_t                side1_nxt, side3_nxt, side6_nxt;
  logic [56:0]          slat_sum [2];
  logic [46:0]          term_prod [2];
  logic [30:0]          factor [2];
  logic [62:0]          sax_sum [2];
  logic signed [TW-1:0] z_fold [2];

  always_comb begin
    side1_nxt     = '0;
    side1_nxt.len = in_len;
    for (int k = 0; k < 2; k++) begin
      neg17[k] = 17'd0 - {in_bend[k][15], in_bend[k]};
      mag[k]   = in_bend[k][15] ? neg17[k][15:0] : in_bend[k];
      // A zero angle always takes the series form, whatever the limit.
      ser[k]   = (in_bend[k] == 16'sd0) || (mag[k] < {8'd0, in_lim});
      side1_nxt.ax[k].x_neg = in_bend[k][15];
      side1_nxt.ax[k].ser   = ser[k];
      side1_nxt.ax[k].mag   = mag[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (th1_r[k] > Q28_PI) begin
        th2_nxt[k] = th1_r[k] - Q28_TWOPI;
      end else if (th1_r[k] < -Q28_PI) begin
        th2_nxt[k] = th1_r[k] + Q28_TWOPI;
      end else begin
        th2_nxt[k] = th1_r[k];
      end
    end
  end

  always_comb begin
    side3_nxt = side2_r;
    for (int k = 0; k < 2; k++) begin
      rot3_nxt[k].x = Q28_KINV;
      rot3_nxt[k].y = '0;
      if (th2_r[k] > Q28_HPI) begin
        z_fold[k]        = Q28_PI - th2_r[k];
        rot3_nxt[k].flip = 1'b1;
      end else if (th2_r[k] < -Q28_HPI) begin
        z_fold[k]        = -Q28_PI - th2_r[k];
        rot3_nxt[k].flip = 1'b1;
      end else begin
        z_fold[k]        = th2_r[k];
        rot3_nxt[k].flip = 1'b0;
      end
      rot3_nxt[k].z = z_fold[k][ZW-1:0];
      slat_sum[k]   = {1'b0, latp2_r[k]} + (57'd1 << 43);
      side3_nxt.ax[k].slat = slat_sum[k][56:44];
    end
  end

  always_comb begin
    side6_nxt = side5_r;
    for (int k = 0; k < 2; k++) begin
      term_prod[k] = qp3_r[k] * RECIP6;
      factor[k]    = (31'd1 << 30) - {10'd0, term4_r[k]};
      sax_sum[k]   = axp5_r[k] + (63'd1 << 44);
      side6_nxt.ax[k].sax = sax_sum[k][62:45];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    lf1_r   <= in_len * in_frac;
    ff1_r   <= in_frac * in_frac;
    side1_r <= side1_nxt;
    lf2_r   <= lf1_r;
    side2_r <= side1_r;
    lf3_r   <= lf2_r;
    side3_r <= side3_nxt;
    rot3_r  <= rot3_nxt;
    lf4_r   <= lf3_r;
    side4_r <= side3_r;
    rot4_r  <= rot3_r;
    side5_r <= side4_r;
    rot5_r  <= rot4_r;
    side6_r <= side6_nxt;
    rot6_r  <= rot5_r;
    for (int k = 0; k < 2; k++) begin
      th1_r[k]   <= in_bend[k] * $signed({1'b0, in_frac});
      fm1_r[k]   <= in_frac * mag[k][7:0];
      msq1_r[k]  <= mag[k][7:0] * mag[k][7:0];
      th2_r[k]   <= th2_nxt[k];
      latp2_r[k] <= lf1_r * fm1_r[k];
      q2_r[k]    <= ff1_r * msq1_r[k];
      qp3_r[k]   <= {1'b0, q2_r[k][47:26]} + 23'd3;
      term4_r[k] <= term_prod[k][46:26];
      axp5_r[k]  <= lf4_r * factor[k];
    end
  end

  assign out_vld  = v6_r;
  assign out_rot  = rot6_r;
  assign out_side = side6_r;

endmodule

`default_nettype wire

@@ sv/bsp_cordic_cell.sv @@
`default_nettype none

module bsp_cordic_cell import bsp_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  rot_t [1:0] in_rot,
  input  side_t      in_side,
  output logic       out_vld,
  output rot_t [1:0] out_rot,
  output side_t      out_side
);

  localparam logic signed [ZW-1:0] ATAN = atan_q28(STAGE);

  logic                 vld_r;
  rot_t [1:0]           rot_r;
  side_t                side_r;
  rot_t [1:0]           rot_nxt;
  logic signed [ZW-1:0] dx [2];
  logic signed [ZW-1:0] dy [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dx[k] = in_rot[k].y >>> STAGE;
      dy[k] = in_rot[k].x >>> STAGE;
      rot_nxt[k].flip = in_rot[k].flip;
      if (!in_rot[k].z[ZW-1]) begin
        rot_nxt[k].x = in_rot[k].x - dx[k];
        rot_nxt[k].y = in_rot[k].y + dy[k];
        rot_nxt[k].z = in_rot[k].z - ATAN;
      end else begin
        rot_nxt[k].x = in_rot[k].x + dx[k];
        rot_nxt[k].y = in_rot[k].y - dy[k];
        rot_nxt[k].z = in_rot[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rot_r  <= rot_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rot  = rot_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

@@ sv/bsp_div_cell.sv @@
`default_nettype none

module bsp_div_cell import bsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  dlane_t [3:0] in_lane,
  input  side_t        in_side,
  output logic         out_vld,
  output dlane_t [3:0] out_lane,
  output side_t        out_side
);

  // Lanes 0 and 1 divide by the first angle, lanes 2 and 3 by the second.
  // Each cell settles one quotient bit; the quotient shifts in at the bottom
  // of num as the dividend shifts out at the top.
  logic         vld_r;
  dlane_t [3:0] lane_r;
  side_t        side_r;
  dlane_t [3:0] lane_nxt;
  logic [16:0]  trial [4];
  logic [16:0]  dsor  [4];
  logic         ge    [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dsor[k]  = {1'b0, in_side.ax[k / 2].mag};
      trial[k] = {in_lane[k].rem, in_lane[k].num[DIV_W-1]};
      ge[k]    = trial[k] >= dsor[k];
      lane_nxt[k].rem = ge[k] ? 16'(trial[k] - dsor[k]) : trial[k][15:0];
      lane_nxt[k].num = {in_lane[k].num[DIV_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;
  assign out_side = side_r;

endmodule

`default_nettype wire
